### hw/rtl/tssg_pkg.sv
// Shared types and constants of the triangle span generator.
package tssg_pkg;

   localparam int XW    = 10;
   localparam int YW    = 6;
   localparam int CW    = 32;
   localparam int LANES = 3;
   localparam int CNTW  = $clog2(XW);

   // Lane numbering of the long, upper and lower edges.
   localparam int LANE_LONG   = 0;
   localparam int LANE_UPPER  = 1;
   localparam int LANE_LOWER  = 2;

   typedef logic [XW-1:0] x_type;
   typedef logic [YW-1:0] y_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic flat;
      logic last_row;
   } status_type;

endpackage

### hw/rtl/triangle_scanline_span_generator_core.sv
// Top level of the triangle span generator.
// One triangle word is taken at a time. It is sorted by row and loaded, then the long,
// upper and lower edge slopes are divided in parallel by restoring dividers, one
// quotient bit a cycle, after which one span word leaves per cycle while the output is
// not stalled, for every row from the top vertex down to the row above the bottom
// vertex. The next triangle is taken as soon as the last span sits in the output
// register. A triangle whose vertex rows are all equal yields no span word.
module triangle_scanline_span_generator_core #(
   parameter int SCREEN_WIDTH = 1024,
   parameter int TILE_ROWS    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [tssg_pkg::XW-1:0] req_a_x,
   input  logic [tssg_pkg::YW-1:0] req_a_y,
   input  logic [tssg_pkg::XW-1:0] req_b_x,
   input  logic [tssg_pkg::YW-1:0] req_b_y,
   input  logic [tssg_pkg::XW-1:0] req_c_x,
   input  logic [tssg_pkg::YW-1:0] req_c_y,
   input  logic [tssg_pkg::CW-1:0] req_color_rgba,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [tssg_pkg::XW-1:0] rsp_span_x,
   output logic [tssg_pkg::YW-1:0] rsp_span_row,
   output logic [tssg_pkg::XW-1:0] rsp_span_width,
   output logic [tssg_pkg::CW-1:0] rsp_span_color,
   output logic                  rsp_last_span
);
   import tssg_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing of load, divide and row output.
   tssg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and storage.
   tssg_datapath #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .TILE_ROWS    (TILE_ROWS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .status     (status),
      .a_x        (req_a_x),
      .a_y        (req_a_y),
      .b_x        (req_b_x),
      .b_y        (req_b_y),
      .c_x        (req_c_x),
      .c_y        (req_c_y),
      .color_rgba (req_color_rgba),
      .span_x     (rsp_span_x),
      .span_row   (rsp_span_row),
      .span_width (rsp_span_width),
      .span_color (rsp_span_color),
      .last_span  (rsp_last_span)
   );

endmodule

### hw/rtl/tssg_ctrl.sv
// Controller state machine of the triangle span generator.
module tssg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tssg_pkg::cmd_type    cmd,
   input  tssg_pkg::status_type status
);
   import tssg_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_RUN    = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == CNTW'(XW - 1)) begin
               state_in = status.flat ? ST_IDLE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.last_row) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/tssg_datapath.sv
// Datapath of the triangle span generator: vertex sort, edge dividers and row stepping.
module tssg_datapath #(
   parameter int SCREEN_WIDTH = 1024,
   parameter int TILE_ROWS    = 64
) (
   input  logic                  clock,
   input  tssg_pkg::cmd_type      cmd,
   output tssg_pkg::status_type   status,
   input  logic [tssg_pkg::XW-1:0] a_x,
   input  logic [tssg_pkg::YW-1:0] a_y,
   input  logic [tssg_pkg::XW-1:0] b_x,
   input  logic [tssg_pkg::YW-1:0] b_y,
   input  logic [tssg_pkg::XW-1:0] c_x,
   input  logic [tssg_pkg::YW-1:0] c_y,
   input  logic [tssg_pkg::CW-1:0] color_rgba,
   output logic [tssg_pkg::XW-1:0] span_x,
   output logic [tssg_pkg::YW-1:0] span_row,
   output logic [tssg_pkg::XW-1:0] span_width,
   output logic [tssg_pkg::CW-1:0] span_color,
   output logic                  last_span
);
   import tssg_pkg::*;

   localparam int XMAX_I = (SCREEN_WIDTH - 1 > 1023) ? 1023 : SCREEN_WIDTH - 1;
   localparam int YMAX_I = (TILE_ROWS - 1 > 63) ? 63 : TILE_ROWS - 1;
   localparam x_type X_MAX = XW'(XMAX_I);
   localparam y_type Y_MAX = YW'(YMAX_I);

   // Vertex registers, sorted by row.
   x_type top_x_ff, mid_x_ff, bot_x_ff;
   y_type top_y_ff, mid_y_ff, bot_y_ff;
   logic [CW-1:0] color_ff;

   // Per-lane divider state.
   x_type dvd_ff [LANES];
   x_type quo_ff [LANES];
   y_type rem_ff [LANES];

   // Row stepping state.
   y_type row_ff;
   logic  lower_ff;
   x_type lq_ff, sq_ff;
   y_type lr_ff, sr_ff;

   // Output word registers.
   x_type         out_x_ff, out_w_ff;
   y_type         out_row_ff;
   logic [CW-1:0] out_color_ff;
   logic          out_last_ff;

   // Clamp and sort network.
   x_type cx0, cx1, cx2, sx0, sx1, sx2, tx;
   y_type cy0, cy1, cy2, sy0, sy1, sy2, ty;
   always_comb begin
      tx  = '0;
      ty  = '0;
      cx0 = (a_x > X_MAX) ? X_MAX : a_x;
      cx1 = (b_x > X_MAX) ? X_MAX : b_x;
      cx2 = (c_x > X_MAX) ? X_MAX : c_x;
      cy0 = (a_y > Y_MAX) ? Y_MAX : a_y;
      cy1 = (b_y > Y_MAX) ? Y_MAX : b_y;
      cy2 = (c_y > Y_MAX) ? Y_MAX : c_y;
      sx0 = cx0; sy0 = cy0; sx1 = cx1; sy1 = cy1; sx2 = cx2; sy2 = cy2;
      if (sy0 > sy1) begin
         tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
      end
      if (sy1 > sy2) begin
         tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
      end
      if (sy0 > sy1) begin
         tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
      end
   end

   // Edge deltas from the stored vertices.
   x_type adx [LANES];
   y_type dy  [LANES];
   logic  neg [LANES];
   always_comb begin
      neg[LANE_LONG]  = bot_x_ff < top_x_ff;
      adx[LANE_LONG]  = neg[LANE_LONG] ? top_x_ff - bot_x_ff : bot_x_ff - top_x_ff;
      dy[LANE_LONG]   = bot_y_ff - top_y_ff;
      neg[LANE_UPPER] = mid_x_ff < top_x_ff;
      adx[LANE_UPPER] = neg[LANE_UPPER] ? top_x_ff - mid_x_ff : mid_x_ff - top_x_ff;
      dy[LANE_UPPER]  = mid_y_ff - top_y_ff;
      neg[LANE_LOWER] = bot_x_ff < mid_x_ff;
      adx[LANE_LOWER] = neg[LANE_LOWER] ? mid_x_ff - bot_x_ff : bot_x_ff - mid_x_ff;
      dy[LANE_LOWER]  = bot_y_ff - mid_y_ff;
   end

   // One restoring division step per lane.
   logic [YW:0] trial [LANES];
   logic        qbit  [LANES];
   y_type       rnext [LANES];
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         trial[i] = {rem_ff[i], dvd_ff[i][XW-1]};
         qbit[i]  = trial[i] >= {1'b0, dy[i]};
         rnext[i] = qbit[i] ? YW'(trial[i] - {1'b0, dy[i]}) : trial[i][YW-1:0];
      end
   end

   // Edge x values and the span of the current row.
   y_type       s_dy, s_r0;
   x_type       s_q0, s_vx;
   logic        s_neg;
   logic [XW:0] xl, xs;
   x_type       lo, wd;
   always_comb begin
      s_dy  = lower_ff ? dy[LANE_LOWER] : dy[LANE_UPPER];
      s_q0  = lower_ff ? quo_ff[LANE_LOWER] : quo_ff[LANE_UPPER];
      s_r0  = lower_ff ? rem_ff[LANE_LOWER] : rem_ff[LANE_UPPER];
      s_neg = lower_ff ? neg[LANE_LOWER] : neg[LANE_UPPER];
      s_vx  = lower_ff ? mid_x_ff : top_x_ff;
      xl = neg[LANE_LONG] ? {1'b0, top_x_ff} - {1'b0, lq_ff}
                          : {1'b0, top_x_ff} + {1'b0, lq_ff};
      xs = s_neg ? {1'b0, s_vx} - {1'b0, sq_ff} : {1'b0, s_vx} + {1'b0, sq_ff};
      if (xl[XW-1:0] < xs[XW-1:0]) begin
         lo = xl[XW-1:0];
         wd = xs[XW-1:0] - xl[XW-1:0];
      end else begin
         lo = xs[XW-1:0];
         wd = xl[XW-1:0] - xs[XW-1:0];
      end
   end

   // Accumulator steps to the next row.
   logic [YW:0] lsum, ssum;
   y_type       row_next;
   x_type       lq_in, sq_in;
   y_type       lr_in, sr_in;
   logic        lower_in;
   always_comb begin
      row_next = row_ff + 1'b1;
      lsum = {1'b0, lr_ff} + {1'b0, rem_ff[LANE_LONG]};
      if (lsum >= {1'b0, dy[LANE_LONG]}) begin
         lr_in = YW'(lsum - {1'b0, dy[LANE_LONG]});
         lq_in = lq_ff + quo_ff[LANE_LONG] + 1'b1;
      end else begin
         lr_in = lsum[YW-1:0];
         lq_in = lq_ff + quo_ff[LANE_LONG];
      end
      ssum = {1'b0, sr_ff} + {1'b0, s_r0};
      lower_in = lower_ff;
      if (row_next == mid_y_ff) begin
         sr_in    = '0;
         sq_in    = '0;
         lower_in = 1'b1;
      end else if (ssum >= {1'b0, s_dy}) begin
         sr_in = YW'(ssum - {1'b0, s_dy});
         sq_in = sq_ff + s_q0 + 1'b1;
      end else begin
         sr_in = ssum[YW-1:0];
         sq_in = sq_ff + s_q0;
      end
   end

   assign status.flat     = (top_y_ff == bot_y_ff);
   assign status.last_row = (row_ff == bot_y_ff - 1'b1);

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         top_x_ff <= sx0; top_y_ff <= sy0;
         mid_x_ff <= sx1; mid_y_ff <= sy1;
         bot_x_ff <= sx2; bot_y_ff <= sy2;
         color_ff <= color_rgba;
         row_ff   <= sy0;
         lower_ff <= (sy0 == sy1);
         lq_ff <= '0; lr_ff <= '0; sq_ff <= '0; sr_ff <= '0;
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= '0;
            quo_ff[i] <= '0;
         end
         dvd_ff[LANE_LONG]  <= (sx2 < sx0) ? sx0 - sx2 : sx2 - sx0;
         dvd_ff[LANE_UPPER] <= (sx1 < sx0) ? sx0 - sx1 : sx1 - sx0;
         dvd_ff[LANE_LOWER] <= (sx2 < sx1) ? sx1 - sx2 : sx2 - sx1;
      end
      if (cmd.div_step) begin
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= rnext[i];
            quo_ff[i] <= {quo_ff[i][XW-2:0], qbit[i]};
            dvd_ff[i] <= {dvd_ff[i][XW-2:0], 1'b0};
         end
      end
      if (cmd.emit) begin
         out_x_ff     <= lo;
         out_w_ff     <= wd;
         out_row_ff   <= row_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= status.last_row;
         row_ff   <= row_next;
         lq_ff    <= lq_in;
         lr_ff    <= lr_in;
         sq_ff    <= sq_in;
         sr_ff    <= sr_in;
         lower_ff <= lower_in;
      end
   end

   assign span_x     = out_x_ff;
   assign span_row   = out_row_ff;
   assign span_width = out_w_ff;
   assign span_color = out_color_ff;
   assign last_span  = out_last_ff;

endmodule
